@@ design/lbp3_pkg.sv @@
// Package with shared types and constants for the 3x3 texture code block.
`timescale 1ns / 1ps
package lbp3_pkg;

    localparam int WIDTH_CFG_W  = 11;
    localparam int HEIGHT_CFG_W = 13;
    localparam int IN_ROW_W     = HEIGHT_CFG_W + 1;
    localparam int CFG_INDEX_W  = 2;
    localparam int CFG_DATA_W   = 13;

    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;

    localparam logic [WIDTH_CFG_W-1:0]  RESET_WIDTH  = 11'd640;
    localparam logic [HEIGHT_CFG_W-1:0] RESET_HEIGHT = 13'd480;

    localparam logic [7:0] OUTSIDE_GRAY = 8'd255;

    typedef struct packed {
        logic [7:0] chan_first;
        logic [7:0] chan_second;
        logic [7:0] chan_third;
        logic       drain;
    } t_in_item;

    typedef struct packed {
        logic [7:0] texture_code;
        logic       frame_end;
    } t_out_item;

endpackage

@@ design/lbp3_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module lbp3_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/local_binary_pattern_3x3.sv @@
// The code of a pixel reaches the output register in the cycle after the item that
// completes its window is taken; that item comes one row plus one item later.
// Throughput: one item per cycle unless stalled; the line store is read ahead at
// the next column and a write to the same entry is forwarded around the RAM.
// Input stalls only while a stalled output holds a result or i_cfg_valid is high.
// Reset: positions, window clear; size 640 (<= MAX_WIDTH) x 480; line store kept.
`timescale 1ns / 1ps
module local_binary_pattern_3x3
    import lbp3_pkg::*;
#(
    parameter int MAX_WIDTH      = 1024,
    parameter int GRAY_FRAC_BITS = 8
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  t_in_item               i_in_data,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output t_out_item              o_out_data,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int GRAY_ONE = 1 << GRAY_FRAC_BITS;
    localparam int WGT_A    = (299 * GRAY_ONE + 500) / 1000;
    localparam int WGT_B    = (587 * GRAY_ONE + 500) / 1000;
    localparam int WGT_C    = (114 * GRAY_ONE + 500) / 1000;
    localparam int GW       = $clog2(255 * (WGT_A + WGT_B + WGT_C) + 1);
    localparam int AW       = $clog2(MAX_WIDTH);
    localparam int WW       = $clog2(MAX_WIDTH + 1);
    localparam int CMPW     = (WW > WIDTH_CFG_W) ? WW : WIDTH_CFG_W;
    localparam int RST_W    = (640 > MAX_WIDTH) ? MAX_WIDTH : 640;

    logic [WW-1:0]           r_width, n_width;
    logic [HEIGHT_CFG_W-1:0] r_height, n_height;
    logic [AW-1:0]           r_in_col, n_in_col;
    logic [IN_ROW_W-1:0]     r_in_row, n_in_row;
    logic [AW-1:0]           r_out_col, n_out_col;
    logic [HEIGHT_CFG_W-1:0] r_out_row, n_out_row;
    logic [GW-1:0]           r_win [9];
    logic [GW-1:0]           n_win [9];
    logic                    r_out_valid, n_out_valid;
    t_out_item               r_out_data, n_out_data;
    logic                    r_byp, n_byp;
    logic [2*GW-1:0]         r_byp_data;

    logic                    step;
    logic                    ram_we;
    logic [AW-1:0]           ram_waddr;
    logic [2*GW-1:0]         ram_wdata;
    logic [2*GW-1:0]         ram_rdata;
    logic [2*GW-1:0]         line_q;
    logic                    emit;

    function automatic logic below_bit(input logic [GW-1:0] nb, input logic in_img,
                                       input logic [GW-1:0] ctr);
        logic [GW-1:0] v;
        v = in_img ? ((nb >> GRAY_FRAC_BITS) << GRAY_FRAC_BITS)
                   : ({{(GW-8){1'b0}}, OUTSIDE_GRAY} << GRAY_FRAC_BITS);
        return v < ctr;
    endfunction

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_out_valid & i_out_stall) | i_cfg_valid;
    assign step        = i_in_valid & ~o_in_stall;
    assign line_q      = r_byp ? r_byp_data : ram_rdata;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    lbp3_ram #(
        .WIDTH(2 * GW),
        .DEPTH(MAX_WIDTH)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (n_in_col),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        logic                tail;
        logic                restart;
        logic [AW-1:0]       col_e;
        logic [IN_ROW_W-1:0] row_e;
        logic [AW-1:0]       ocol_e;
        logic [HEIGHT_CFG_W-1:0] orow_e;
        logic [GW-1:0]       gray;
        logic                up, down, left, right, last;
        logic [7:0]          code;
        logic [WW-1:0]       col_inc;
        logic [WW-1:0]       ocol_inc;
        logic [CMPW-1:0]     wval;

        n_width     = r_width;
        n_height    = r_height;
        n_in_col    = r_in_col;
        n_in_row    = r_in_row;
        n_out_col   = r_out_col;
        n_out_row   = r_out_row;
        n_win       = r_win;
        n_out_valid = r_out_valid & i_out_stall;
        n_out_data  = r_out_data;
        ram_we      = 1'b0;
        emit        = 1'b0;

        tail    = {1'b0, r_height} <= r_in_row;
        restart = ~i_in_data.drain & tail;
        col_e   = restart ? '0 : r_in_col;
        row_e   = restart ? '0 : r_in_row;
        ocol_e  = restart ? '0 : r_out_col;
        orow_e  = restart ? '0 : r_out_row;
        gray    = i_in_data.drain ? '0
                : GW'(WGT_A) * GW'(i_in_data.chan_first)
                + GW'(WGT_B) * GW'(i_in_data.chan_second)
                + GW'(WGT_C) * GW'(i_in_data.chan_third);
        ram_waddr = col_e;
        ram_wdata = {line_q[GW-1:0], gray};

        up    = orow_e != '0;
        down  = ({1'b0, orow_e} + 1'b1) < {1'b0, r_height};
        left  = ocol_e != '0;
        ocol_inc = WW'(ocol_e) + 1'b1;
        col_inc  = WW'(col_e) + 1'b1;
        right = ocol_inc < r_width;
        last  = ~down & ~right;

        n_win[0] = r_win[1];
        n_win[1] = r_win[2];
        n_win[2] = line_q[2*GW-1:GW];
        n_win[3] = r_win[4];
        n_win[4] = r_win[5];
        n_win[5] = line_q[GW-1:0];
        n_win[6] = r_win[7];
        n_win[7] = r_win[8];
        n_win[8] = gray;

        code = {below_bit(n_win[0], up & left,   n_win[4]),
                below_bit(n_win[1], up,          n_win[4]),
                below_bit(n_win[2], up & right,  n_win[4]),
                below_bit(n_win[3], left,        n_win[4]),
                below_bit(n_win[5], right,       n_win[4]),
                below_bit(n_win[6], down & left, n_win[4]),
                below_bit(n_win[7], down,        n_win[4]),
                below_bit(n_win[8], down & right, n_win[4])};

        wval = CMPW'(i_cfg_data[WIDTH_CFG_W-1:0]);

        if (i_cfg_valid) begin
            n_win = r_win;
            if (i_cfg_index == CFG_IMAGE_WIDTH) begin
                if (wval == '0) begin
                    n_width = WW'(1);
                end else if (wval > CMPW'(MAX_WIDTH)) begin
                    n_width = WW'(MAX_WIDTH);
                end else begin
                    n_width = wval[WW-1:0];
                end
            end else if (i_cfg_index == CFG_IMAGE_HEIGHT) begin
                n_height = (i_cfg_data == '0) ? HEIGHT_CFG_W'(1) : i_cfg_data;
            end
            if (i_cfg_index == CFG_IMAGE_WIDTH || i_cfg_index == CFG_IMAGE_HEIGHT) begin
                n_in_col  = '0;
                n_in_row  = '0;
                n_out_col = '0;
                n_out_row = '0;
            end
        end else if (step && !(i_in_data.drain && !tail)) begin
            ram_we = 1'b1;
            emit   = (row_e >= IN_ROW_W'(2)) || (row_e == IN_ROW_W'(1) && col_e != '0);
            n_in_col  = col_e;
            n_in_row  = row_e;
            n_out_col = ocol_e;
            n_out_row = orow_e;
            if (emit) begin
                n_out_valid = 1'b1;
                n_out_data  = '{texture_code: code, frame_end: last};
            end
            if (emit && last) begin
                n_in_col  = '0;
                n_in_row  = '0;
                n_out_col = '0;
                n_out_row = '0;
            end else begin
                if (emit) begin
                    if (ocol_inc >= r_width) begin
                        n_out_col = '0;
                        n_out_row = orow_e + 1'b1;
                    end else begin
                        n_out_col = ocol_inc[AW-1:0];
                    end
                end
                if (col_inc >= r_width) begin
                    n_in_col = '0;
                    n_in_row = row_e + 1'b1;
                end else begin
                    n_in_col = col_inc[AW-1:0];
                end
            end
        end else begin
            n_win = r_win;
        end

        n_byp = ram_we && (ram_waddr == n_in_col);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width     <= WW'(RST_W);
            r_height    <= RESET_HEIGHT;
            r_in_col    <= '0;
            r_in_row    <= '0;
            r_out_col   <= '0;
            r_out_row   <= '0;
            r_out_valid <= 1'b0;
            r_byp       <= 1'b0;
            for (int i = 0; i < 9; i++) begin
                r_win[i] <= '0;
            end
        end else begin
            r_width     <= n_width;
            r_height    <= n_height;
            r_in_col    <= n_in_col;
            r_in_row    <= n_in_row;
            r_out_col   <= n_out_col;
            r_out_row   <= n_out_row;
            r_out_valid <= n_out_valid;
            r_byp       <= n_byp;
            r_win       <= n_win;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
        r_byp_data <= ram_wdata;
    end

    a_in_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        WW'(r_in_col) < r_width)
        else $error("input column beyond row width");

    a_out_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (WW'(r_out_col) < r_width) && (r_out_row < r_height))
        else $error("output position outside frame");

    a_byp_after_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_byp |-> $past(ram_we))
        else $error("forwarding without a preceding line store write");

    a_out_from_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(step))
        else $error("result appeared without an accepted request");

endmodule
